// ===== design/wuss_pkg.sv =====
// Package for the weighted unit-slot scheduler: sizes, widths and the
// sequencer state type. No dependencies.
package wuss_pkg;

  localparam int MAX_JOBS = 1024;
  localparam int AW       = $clog2(MAX_JOBS);
  localparam int CW       = $clog2(MAX_JOBS + 1);
  localparam int REL_W    = 32;
  localparam int WT_W     = 20;
  localparam int SLOT_W   = 33;
  localparam int PROD_W   = SLOT_W + WT_W;
  localparam int COST_W   = 63;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_WAIT,
    S_DECIDE,
    S_MUL,
    S_ACC,
    S_DONE
  } wuss_state_t;

endpackage

// ===== design/weighted_unit_slot_scheduler_unit.sv =====
// Weighted unit-slot scheduler: top level with the job store and sequencer.
// Depends on wuss_pkg.
//
// Jobs are loaded one word per clock cycle while busy is low; a word with
// in_last_job set starts the scheduling pass and raises busy. The pass
// places one job per time slot, each placement costing a full scan of the
// job store through its single read port; a scan that finds no released
// job instead moves time to the earliest pending release and scans again.
// The total is then shown on out_total_cost and out_overflow for exactly
// one cycle, marked by out_valid; the receiver cannot stall it, so it must
// take the word in that cycle. busy falls in the cycle after. Jobs beyond
// the store depth are dropped and reported through out_overflow, as is a
// total that saturates at the largest 63-bit value.
module weighted_unit_slot_scheduler_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [wuss_pkg::REL_W-1:0]   in_release_slot,
  input  logic [wuss_pkg::WT_W-1:0]    in_job_weight,
  input  logic                         in_last_job,
  output logic                         out_valid,
  output logic [wuss_pkg::COST_W-1:0]  out_total_cost,
  output logic                         out_overflow
);

  localparam int MW = 1 + wuss_pkg::WT_W + wuss_pkg::REL_W;

  // Each store word holds the placed mark, the weight and the release slot.
  logic [MW-1:0] mem [wuss_pkg::MAX_JOBS];

  wuss_pkg::wuss_state_t state_r, state_nxt;

  logic [wuss_pkg::CW-1:0]     job_count_r;
  logic [wuss_pkg::CW-1:0]     left_r;
  logic [wuss_pkg::CW-1:0]     scan_cnt_r;
  logic [wuss_pkg::SLOT_W-1:0] slot_r;
  logic [wuss_pkg::COST_W-1:0] acc_r;
  logic                        sat_r;
  logic                        store_ovf_r;

  logic [MW-1:0]               rd_data_r;
  logic                        rd_vld_r;
  logic [wuss_pkg::AW-1:0]     rd_idx_r;

  logic                        found_r;
  logic [wuss_pkg::AW-1:0]     best_idx_r;
  logic [wuss_pkg::REL_W-1:0]  best_rel_r;
  logic [wuss_pkg::WT_W-1:0]   best_wt_r;
  logic [wuss_pkg::REL_W-1:0]  earliest_r;
  logic [wuss_pkg::PROD_W-1:0] prod_r;

  logic                        load;
  logic                        wr_en;
  logic [wuss_pkg::AW-1:0]     wr_addr;
  logic [MW-1:0]               wr_data;
  logic                        rd_en;
  logic                        scan_clr;
  logic                        scan_last;

  logic                        rd_placed;
  logic [wuss_pkg::WT_W-1:0]   rd_wt;
  logic [wuss_pkg::REL_W-1:0]  rd_rel;
  logic                        rd_ready;
  logic                        rd_better;
  logic [wuss_pkg::SLOT_W-1:0] delay;
  logic [wuss_pkg::COST_W:0]   sum;

  assign load      = start && !busy;
  assign scan_last = (scan_cnt_r == job_count_r - 1'b1);

  assign rd_placed = rd_data_r[MW-1];
  assign rd_wt     = rd_data_r[wuss_pkg::REL_W +: wuss_pkg::WT_W];
  assign rd_rel    = rd_data_r[wuss_pkg::REL_W-1:0];
  assign rd_ready  = ({1'b0, rd_rel} <= slot_r);
  assign rd_better = !found_r || (rd_wt > best_wt_r) ||
                     ((rd_wt == best_wt_r) && (rd_rel > best_rel_r));

  assign delay = slot_r - {1'b0, best_rel_r};
  assign sum   = {1'b0, acc_r} + {{(wuss_pkg::COST_W + 1 - wuss_pkg::PROD_W){1'b0}}, prod_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wuss_pkg::S_LOAD:   if (load && in_last_job) state_nxt = wuss_pkg::S_SCAN;
      wuss_pkg::S_SCAN:   if (scan_last) state_nxt = wuss_pkg::S_WAIT;
      wuss_pkg::S_WAIT:   state_nxt = wuss_pkg::S_DECIDE;
      wuss_pkg::S_DECIDE: state_nxt = found_r ? wuss_pkg::S_MUL : wuss_pkg::S_SCAN;
      wuss_pkg::S_MUL:    state_nxt = wuss_pkg::S_ACC;
      wuss_pkg::S_ACC:    state_nxt = (left_r == wuss_pkg::CW'(1)) ? wuss_pkg::S_DONE :
                                                                     wuss_pkg::S_SCAN;
      wuss_pkg::S_DONE:   state_nxt = wuss_pkg::S_LOAD;
      default:            state_nxt = wuss_pkg::S_LOAD;
    endcase
  end

  // Outputs and store control.
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = best_idx_r;
    wr_data   = {1'b1, best_wt_r, best_rel_r};
    scan_clr  = 1'b0;
    unique case (state_r)
      wuss_pkg::S_LOAD: begin
        busy     = 1'b0;
        wr_en    = load && (job_count_r < wuss_pkg::CW'(wuss_pkg::MAX_JOBS));
        wr_addr  = job_count_r[wuss_pkg::AW-1:0];
        wr_data  = {1'b0, in_job_weight, in_release_slot};
        scan_clr = 1'b1;
      end
      wuss_pkg::S_SCAN:   rd_en = 1'b1;
      wuss_pkg::S_DECIDE: scan_clr = !found_r;
      wuss_pkg::S_ACC: begin
        wr_en    = 1'b1;
        scan_clr = 1'b1;
      end
      wuss_pkg::S_DONE:   out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_total_cost = acc_r;
  assign out_overflow   = sat_r || store_ovf_r;

  // Job store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[scan_cnt_r[wuss_pkg::AW-1:0]];
    rd_idx_r  <= scan_cnt_r[wuss_pkg::AW-1:0];
  end

  // Payload of the current scan and placement.
  always_ff @(posedge clk) begin
    if (rd_vld_r && !rd_placed && rd_ready && rd_better) begin
      best_idx_r <= rd_idx_r;
      best_rel_r <= rd_rel;
      best_wt_r  <= rd_wt;
    end
    if (scan_clr) begin
      earliest_r <= {wuss_pkg::REL_W{1'b1}};
    end else if (rd_vld_r && !rd_placed && (rd_rel < earliest_r)) begin
      earliest_r <= rd_rel;
    end
    prod_r <= delay * best_wt_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wuss_pkg::S_LOAD;
      job_count_r <= '0;
      left_r      <= '0;
      scan_cnt_r  <= '0;
      slot_r      <= '0;
      acc_r       <= '0;
      sat_r       <= 1'b0;
      store_ovf_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;

      if (scan_clr) begin
        found_r <= 1'b0;
      end else if (rd_vld_r && !rd_placed && rd_ready) begin
        found_r <= 1'b1;
      end

      if (rd_en && !scan_last) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end else if (rd_en) begin
        scan_cnt_r <= '0;
      end

      unique case (state_r)
        wuss_pkg::S_LOAD: begin
          if (load) begin
            if (job_count_r < wuss_pkg::CW'(wuss_pkg::MAX_JOBS)) begin
              job_count_r <= job_count_r + 1'b1;
              left_r      <= job_count_r + 1'b1;
            end else begin
              store_ovf_r <= 1'b1;
            end
          end
        end
        wuss_pkg::S_DECIDE: begin
          if (!found_r) begin
            slot_r <= {1'b0, earliest_r};
          end
        end
        wuss_pkg::S_ACC: begin
          if (sum > {1'b0, wuss_pkg::COST_MAX}) begin
            acc_r <= wuss_pkg::COST_MAX;
            sat_r <= 1'b1;
          end else begin
            acc_r <= sum[wuss_pkg::COST_W-1:0];
          end
          slot_r <= slot_r + 1'b1;
          left_r <= left_r - 1'b1;
        end
        wuss_pkg::S_DONE: begin
          job_count_r <= '0;
          left_r      <= '0;
          slot_r      <= '0;
          acc_r       <= '0;
          sat_r       <= 1'b0;
          store_ovf_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/wuss_checker.sv =====
// Port-level checker for the weighted unit-slot scheduler and its bind.
// Depends on weighted_unit_slot_scheduler_unit's ports only.
module wuss_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_job,
  input logic out_valid
);

  // A result word only appears during a pass.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a pass");

  // The block is ready again right after its result word.
  a_free_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy held after result");

  // A word that is not last keeps the block loading.
  a_load_on: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_job) |=> (!busy && !out_valid))
    else $error("pass started without last word");

  // The last word starts a pass.
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_job) |=> (busy && !out_valid))
    else $error("last word did not start a pass");

endmodule

bind weighted_unit_slot_scheduler_unit wuss_checker u_wuss_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_last_job(in_last_job),
  .out_valid(out_valid)
);

// ===== dv/weighted_unit_slot_scheduler_unit_test.sv =====
// Self-checking test of weighted_unit_slot_scheduler_unit: job sets are
// loaded word by word and each total is compared with an in-bench predictor.
// Depends on wuss_pkg and the scheduler RTL.
module weighted_unit_slot_scheduler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wuss_pkg::*;

  // Generous bound: one full store set dominates the run time, and the
  // random sets add far less.
  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam longint unsigned TOTAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [COST_W-1:0] total_cost;
    logic              overflow;
  } set_total_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [REL_W-1:0] in_release_slot;
  logic [WT_W-1:0] in_job_weight;
  logic in_last_job;
  logic out_valid;
  logic [COST_W-1:0] out_total_cost;
  logic out_overflow;

  // Jobs of the set being loaded, as the scheduler has stored them.
  logic [REL_W-1:0] set_release[$];
  logic [WT_W-1:0] set_weight[$];
  bit set_dropped;
  set_total_t totals_due[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit gaps_on;

  weighted_unit_slot_scheduler_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_release_slot(in_release_slot),
    .in_job_weight  (in_job_weight),
    .in_last_job    (in_last_job),
    .out_valid      (out_valid),
    .out_total_cost (out_total_cost),
    .out_overflow   (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Greedy placement: at every slot take the heaviest released job still
  // pending (on equal weight, the later release); when nothing is released,
  // time jumps to the earliest pending release.
  function automatic set_total_t schedule_cost();
    int n;
    int left;
    int best;
    bit found;
    bit placed[];
    logic [REL_W-1:0] earliest;
    longint unsigned slot;
    longint unsigned acc;
    longint unsigned add;
    bit sat;
    set_total_t res;
    n = set_release.size();
    placed = new[n];
    left = n;
    slot = 0;
    acc = 0;
    sat = 1'b0;
    while (left > 0) begin
      found = 1'b0;
      best = 0;
      earliest = '1;
      for (int i = 0; i < n; i++) begin
        if (!placed[i]) begin
          if (set_release[i] < earliest) earliest = set_release[i];
          if (longint'(set_release[i]) <= slot) begin
            if (!found || set_weight[i] > set_weight[best] ||
                (set_weight[i] == set_weight[best] &&
                 set_release[i] > set_release[best])) begin
              best = i;
              found = 1'b1;
            end
          end
        end
      end
      if (!found) begin
        slot = earliest;
      end else begin
        add = (slot - set_release[best]) * set_weight[best];
        if (add > TOTAL_MAX - acc) begin
          acc = TOTAL_MAX;
          sat = 1'b1;
        end else begin
          acc += add;
        end
        placed[best] = 1'b1;
        slot = (slot + 1) & 64'h1_FFFF_FFFF;
        left--;
      end
    end
    res.total_cost = acc[COST_W-1:0];
    res.overflow = sat | set_dropped;
    return res;
  endfunction

  // Sends one job word and holds it until the scheduler takes it. start is
  // left high afterwards so back-to-back words need no second assignment.
  task automatic send_job(input logic [REL_W-1:0] rel, input logic [WT_W-1:0] wt,
                          input logic last);
    if (gaps_on && $urandom_range(99) < 16) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_release_slot <= rel;
    in_job_weight <= wt;
    in_last_job <= last;
    do @(posedge clk); while (busy);
    if (set_release.size() < MAX_JOBS) begin
      set_release.push_back(rel);
      set_weight.push_back(wt);
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      totals_due.push_back(schedule_cost());
      set_release.delete();
      set_weight.delete();
      set_dropped = 1'b0;
    end
  endtask

  // Checks every result word against the oldest predicted total.
  always @(posedge clk) begin
    set_total_t exp_t;
    if (rst_n && out_valid) begin
      if (totals_due.size() == 0) begin
        $error("result word with no total expected: total_cost %0d", out_total_cost);
        fail_count++;
      end else begin
        exp_t = totals_due.pop_front();
        if (out_total_cost !== exp_t.total_cost) begin
          $error("total_cost expected %0d actual %0d", exp_t.total_cost, out_total_cost);
          fail_count++;
        end
        if (out_overflow !== exp_t.overflow) begin
          $error("overflow expected %0d actual %0d", exp_t.overflow, out_overflow);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Edge values of the fields, ties, zero weights and jumps in time.
  task automatic test_directed();
    send_job('0, '0, 1'b1);
    send_job('1, '1, 1'b1);
    send_job(32'd0, 20'd7, 1'b0);
    send_job(32'd0, 20'd7, 1'b0);
    send_job(32'd1, 20'd7, 1'b1);
    send_job(32'd0, 20'd0, 1'b0);
    send_job(32'd0, 20'hFFFFF, 1'b0);
    send_job(32'd0, 20'd0, 1'b1);
    send_job(32'd100, 20'd3, 1'b0);
    send_job(32'd5, 20'd9, 1'b0);
    send_job(32'd100, 20'hFFFFF, 1'b1);
    // Releases at the top of the range push the slot past 32 bits.
    send_job('1, 20'hFFFFF, 1'b0);
    send_job('1, 20'hAAAAA, 1'b0);
    send_job('1, 20'h55555, 1'b0);
    send_job(32'hFFFF_FFFE, 20'hFFFFF, 1'b1);
    send_job(32'hAAAA_AAAA, 20'h12345, 1'b0);
    send_job(32'h5555_5555, 20'hEDCBA, 1'b1);
  endtask

  // Fills the store and drops two more jobs; the last one still ends the set.
  task automatic test_store_full();
    for (int i = 0; i < MAX_JOBS + 2; i++)
      send_job('0, WT_W'($urandom), i == MAX_JOBS + 1);
  endtask

  // Random sets, mostly small, with releases clustered around a random base
  // so that waiting, jumping and ties all occur.
  task automatic test_random_sets();
    int sent;
    int n;
    int spread;
    logic [REL_W-1:0] base;
    logic [REL_W-1:0] rel;
    logic [WT_W-1:0] wt;
    sent = 0;
    while (sent < 760) begin
      gaps_on = !(sent > 250 && sent < 550);
      n = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      case ($urandom_range(3))
        0: base = '0;
        1: base = '1 - 32'($urandom_range(40));
        default: base = $urandom;
      endcase
      spread = $urandom_range(1, 3 * n);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) rel = $urandom;
        else rel = base + 32'($urandom_range(spread));
        case ($urandom_range(5))
          0: wt = '0;
          1: wt = 20'($urandom_range(3));
          2: wt = '1;
          default: wt = WT_W'($urandom);
        endcase
        send_job(rel, wt, i == n - 1);
      end
      sent += n;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_release_slot <= '0;
    in_job_weight <= '0;
    in_last_job <= 1'b0;
    fail_count = 0;
    cycle_count = 0;
    set_dropped = 1'b0;
    gaps_on = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_store_full();
    test_random_sets();

    start <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/wuss_pkg.sv
design/weighted_unit_slot_scheduler_unit.sv
design/wuss_checker.sv
dv/weighted_unit_slot_scheduler_unit_test.sv
